// ===== sv/wfa_pkg.sv =====
package wfa_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int SIZE_BITS  = 16;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;

    // Fixed field widths of the ports
    localparam int CFG_W = 9;
    localparam int BIDX_W = 8;
    localparam int REQ_W = 16;
    localparam int ID_W = 9;
    localparam int OSZ_W = 16;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [SIZE_BITS-1:0] t_space;
    typedef logic [CMP_W-1:0]     t_cmp;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [BIDX_W-1:0]    t_bidx;
    typedef logic [REQ_W-1:0]     t_req;
    typedef logic [ID_W-1:0]      t_id;
    typedef logic [OSZ_W-1:0]     t_osz;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_LOADED  = 2'd0,
        ST_ALLOC   = 2'd1,
        ST_IMPOSS  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        t_space wdata;
        logic   re;
        t_idx   raddr;
    } t_mem_req;

endpackage

// ===== sv/wfa_mem.sv =====
module wfa_mem (
    input  logic              i_clk,
    input  wfa_pkg::t_mem_req i_req,
    output wfa_pkg::t_space   o_rd_data
);

    wfa_pkg::t_space r_mem [wfa_pkg::MAX_BLOCKS];
    wfa_pkg::t_space r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/wfa_ctrl.sv =====
module wfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_mode,
    input  wfa_pkg::t_bidx    i_block_index,
    input  logic [15:0]       i_size,
    input  wfa_pkg::t_cnt     i_active,
    input  wfa_pkg::t_space   i_rd_data,
    output wfa_pkg::t_mem_req o_mem,
    output logic              o_busy,
    output logic              o_done,
    output wfa_pkg::t_status  o_status,
    output wfa_pkg::t_req     o_request_number,
    output wfa_pkg::t_id      o_block_id,
    output wfa_pkg::t_osz     o_space_before,
    output wfa_pkg::t_osz     o_space_after
);

    wfa_pkg::t_state  r_state, n_state;
    wfa_pkg::t_cnt    r_addr, n_addr;
    logic             r_dv, n_dv;
    wfa_pkg::t_idx    r_didx, n_didx;
    wfa_pkg::t_space  r_best, n_best;
    wfa_pkg::t_idx    r_best_idx, n_best_idx;
    logic [15:0]      r_size, n_size;
    wfa_pkg::t_req    r_req_cnt, n_req_cnt;
    logic             r_done, n_done;
    wfa_pkg::t_status r_status, n_status;
    wfa_pkg::t_req    r_reqnum, n_reqnum;
    wfa_pkg::t_id     r_id, n_id;
    wfa_pkg::t_osz    r_before, n_before;
    wfa_pkg::t_osz    r_after, n_after;

    logic            accept;
    logic            last;
    logic            in_range;
    logic            fits;
    wfa_pkg::t_space after_val;

    assign accept   = i_start && (r_state == wfa_pkg::S_IDLE);
    assign last     = (wfa_pkg::t_cnt'(r_didx) == (i_active - wfa_pkg::t_cnt'(1)));
    assign in_range = (32'(i_block_index) < wfa_pkg::MAX_BLOCKS);
    assign fits     = (wfa_pkg::t_cmp'(r_best) >= wfa_pkg::t_cmp'(r_size));
    assign after_val = fits ? (r_best - wfa_pkg::t_space'(r_size)) : r_best;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wfa_pkg::S_IDLE: begin
                if (accept && (i_mode == wfa_pkg::MODE_ALLOC) && (i_active != '0)) begin
                    n_state = wfa_pkg::S_SCAN;
                end
            end
            wfa_pkg::S_SCAN: begin
                if (r_dv && last) begin
                    n_state = wfa_pkg::S_DECIDE;
                end
            end
            wfa_pkg::S_DECIDE: begin
                n_state = wfa_pkg::S_IDLE;
            end
            default: n_state = wfa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_mem      = '0;
        n_addr     = r_addr;
        n_dv       = 1'b0;
        n_didx     = r_didx;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_size     = r_size;
        n_req_cnt  = r_req_cnt;
        n_done     = 1'b0;
        n_status   = r_status;
        n_reqnum   = r_reqnum;
        n_id       = r_id;
        n_before   = r_before;
        n_after    = r_after;
        unique case (r_state)
            wfa_pkg::S_IDLE: begin
                if (accept && (i_mode == wfa_pkg::MODE_LOAD)) begin
                    n_done   = 1'b1;
                    n_status = wfa_pkg::ST_LOADED;
                    n_reqnum = '0;
                    n_before = '0;
                    if (in_range) begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = wfa_pkg::t_idx'(i_block_index);
                        o_mem.wdata = wfa_pkg::t_space'(i_size);
                        n_id        = wfa_pkg::t_id'(i_block_index) + wfa_pkg::t_id'(1);
                        n_after     = wfa_pkg::t_osz'(wfa_pkg::t_space'(i_size));
                    end else begin
                        n_id    = '0;
                        n_after = '0;
                    end
                end else if (accept) begin
                    n_req_cnt = r_req_cnt + wfa_pkg::t_req'(1);
                    n_reqnum  = r_req_cnt + wfa_pkg::t_req'(1);
                    n_size    = i_size;
                    if (i_active == '0) begin
                        n_done   = 1'b1;
                        n_status = wfa_pkg::ST_IMPOSS;
                        n_id     = '0;
                        n_before = '0;
                        n_after  = '0;
                    end else begin
                        // issue the read of block 0 right away
                        o_mem.re    = 1'b1;
                        o_mem.raddr = '0;
                        n_addr      = wfa_pkg::t_cnt'(1);
                        n_dv        = 1'b1;
                        n_didx      = '0;
                    end
                end
            end
            wfa_pkg::S_SCAN: begin
                if (r_addr < i_active) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = wfa_pkg::t_idx'(r_addr);
                    n_addr      = r_addr + wfa_pkg::t_cnt'(1);
                    n_dv        = 1'b1;
                    n_didx      = wfa_pkg::t_idx'(r_addr);
                end
                // strict compare keeps the lowest id on a tie
                if (r_dv && ((r_didx == '0) || (i_rd_data > r_best))) begin
                    n_best     = i_rd_data;
                    n_best_idx = r_didx;
                end
            end
            wfa_pkg::S_DECIDE: begin
                // no read is in flight here, so the write-back cannot collide
                o_mem.we    = fits;
                o_mem.waddr = r_best_idx;
                o_mem.wdata = after_val;
                n_done      = 1'b1;
                n_status    = fits ? wfa_pkg::ST_ALLOC : wfa_pkg::ST_IMPOSS;
                n_id        = wfa_pkg::t_id'(r_best_idx) + wfa_pkg::t_id'(1);
                n_before    = wfa_pkg::t_osz'(r_best);
                n_after     = wfa_pkg::t_osz'(after_val);
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wfa_pkg::S_IDLE;
            r_dv      <= 1'b0;
            r_done    <= 1'b0;
            r_req_cnt <= '0;
            r_addr    <= '0;
        end else begin
            r_state   <= n_state;
            r_dv      <= n_dv;
            r_done    <= n_done;
            r_req_cnt <= n_req_cnt;
            r_addr    <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx     <= n_didx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_size     <= n_size;
        r_status   <= n_status;
        r_reqnum   <= n_reqnum;
        r_id       <= n_id;
        r_before   <= n_before;
        r_after    <= n_after;
    end

    assign o_busy           = (r_state != wfa_pkg::S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_request_number = r_reqnum;
    assign o_block_id       = r_id;
    assign o_space_before   = r_before;
    assign o_space_after    = r_after;

endmodule

// ===== sv/worst_fit_block_allocator.sv =====
// channel   direction  transaction                       payload
// command   in         start && !busy                    i_mode, i_block_index, i_size
// result    out        o_done (one cycle, no stall)      o_status, o_request_number,
//                                                        o_block_id, o_space_before,
//                                                        o_space_after
// config    in         i_cfg_valid && o_cfg_ready        i_cfg_data (blocks_in_use)
//
// A load's result shows the cycle after start and busy stays low.
// An allocation scans the free-space memory through its single read port, one block per
// cycle; with no blocks in use the result shows the next cycle.
// Reset is synchronous, active low, and clears control state and the request counter;
// the free-space memory is not cleared. The result channel has no back-pressure.
module worst_fit_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [7:0]  i_block_index,
    input  logic [15:0] i_size,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_request_number,
    output logic [8:0]  o_block_id,
    output logic [15:0] o_space_before,
    output logic [15:0] o_space_after,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);

    wfa_pkg::t_cfg     r_blocks_in_use;
    wfa_pkg::t_cnt     active;
    wfa_pkg::t_mem_req mem_req;
    wfa_pkg::t_space   rd_data;
    wfa_pkg::t_status  status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_in_use <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_blocks_in_use <= i_cfg_data;
        end
    end

    // clamp to the table depth
    assign active = (32'(r_blocks_in_use) > wfa_pkg::MAX_BLOCKS)
                    ? wfa_pkg::t_cnt'(wfa_pkg::MAX_BLOCKS)
                    : wfa_pkg::t_cnt'(r_blocks_in_use);

    wfa_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_mode           (i_mode),
        .i_block_index    (i_block_index),
        .i_size           (i_size),
        .i_active         (active),
        .i_rd_data        (rd_data),
        .o_mem            (mem_req),
        .o_busy           (busy),
        .o_done           (o_done),
        .o_status         (status),
        .o_request_number (o_request_number),
        .o_block_id       (o_block_id),
        .o_space_before   (o_space_before),
        .o_space_after    (o_space_after)
    );

    wfa_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign o_status = status;

endmodule

// ===== sv/wfa_checker.sv =====
module wfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [15:0] o_request_number,
    input logic [8:0]  o_block_id,
    input logic [15:0] o_space_before,
    input logic [15:0] o_space_after
);

    // every transaction either finishes next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted transaction neither busy nor done");

    a_end_of_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    a_alloc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == wfa_pkg::ST_ALLOC)) |->
            ((o_block_id != 9'd0) && (o_space_after <= o_space_before)))
        else $error("allocation result inconsistent");

    a_imposs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == wfa_pkg::ST_IMPOSS)) |-> (o_space_before == o_space_after))
        else $error("impossible request changed space");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == wfa_pkg::ST_LOADED)) |->
            ((o_request_number == 16'd0) && (o_space_before == 16'd0)))
        else $error("load result carries allocation fields");

endmodule

bind worst_fit_block_allocator wfa_checker u_wfa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_status         (o_status),
    .o_request_number (o_request_number),
    .o_block_id       (o_block_id),
    .o_space_before   (o_space_before),
    .o_space_after    (o_space_after)
);
